FILE: rtl/core/irpd_pkg.sv
// ----------------------------------------------------------------------------
// irpd_pkg
// Types and constants shared by the infrared pulse-distance encoder modules.
// ----------------------------------------------------------------------------
package irpd_pkg;

  localparam int unsigned CODE_W  = 32;
  localparam int unsigned PRE_W   = 8;
  localparam int unsigned CNT_W   = 6;
  localparam int unsigned TIME_W  = 8;
  localparam int unsigned PREB_W  = 4;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned CDATA_W = 8;

  // register indexes on the configuration channel
  localparam logic [CIDX_W-1:0] REG_NUM_BITS    = 3'd0;
  localparam logic [CIDX_W-1:0] REG_PRE_BITS    = 3'd1;
  localparam logic [CIDX_W-1:0] REG_MARK_TIME   = 3'd2;
  localparam logic [CIDX_W-1:0] REG_SPACE0_TIME = 3'd3;
  localparam logic [CIDX_W-1:0] REG_SPACE1_TIME = 3'd4;
  localparam logic [CIDX_W-1:0] REG_WAIT_TICKS  = 3'd5;

  // reset values
  localparam logic [CNT_W-1:0]  RST_NUM_BITS    = 6'd32;
  localparam logic [PREB_W-1:0] RST_PRE_BITS    = 4'd8;
  localparam logic [TIME_W-1:0] RST_MARK_TIME   = 8'd14;
  localparam logic [TIME_W-1:0] RST_SPACE0_TIME = 8'd7;
  localparam logic [TIME_W-1:0] RST_SPACE1_TIME = 8'd28;
  localparam logic [TIME_W-1:0] RST_WAIT_TICKS  = 8'd170;
  localparam logic [TIME_W-1:0] RST_INTERVAL    = 8'd20;

  // request kinds
  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_START = 1'b1;

  typedef struct packed {
    logic [CNT_W-1:0]  num_bits;
    logic [PREB_W-1:0] pre_bits;
    logic [TIME_W-1:0] mark_time;
    logic [TIME_W-1:0] space0_time;
    logic [TIME_W-1:0] space1_time;
    logic [TIME_W-1:0] wait_ticks;
  } cfg_t;

  typedef struct packed {
    logic              req_type;
    logic [CODE_W-1:0] code_word;
    logic [PRE_W-1:0]  pre_word;
  } item_t;

  typedef struct packed {
    logic              carrier_on;
    logic [TIME_W-1:0] interval_length;
    logic              busy_res;
    logic              start_taken;
  } res_t;

  typedef enum logic [6:0] {
    PH_IDLE  = 7'b0000001,
    PH_PRE_A = 7'b0000010,
    PH_PRE_B = 7'b0000100,
    PH_BIT_A = 7'b0001000,
    PH_BIT_B = 7'b0010000,
    PH_STOP  = 7'b0100000,
    PH_WAIT  = 7'b1000000
  } phase_t;

endpackage

FILE: rtl/core/irpd_cfg.sv
// ----------------------------------------------------------------------------
// irpd_cfg
// Configuration register file: one write channel, six timing registers.
// ----------------------------------------------------------------------------
module irpd_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_en,
  input  logic [irpd_pkg::CIDX_W-1:0]  wr_idx,
  input  logic [irpd_pkg::CDATA_W-1:0] wr_data,
  output irpd_pkg::cfg_t              cfg
);
  import irpd_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.num_bits    <= RST_NUM_BITS;
      cfg_r.pre_bits    <= RST_PRE_BITS;
      cfg_r.mark_time   <= RST_MARK_TIME;
      cfg_r.space0_time <= RST_SPACE0_TIME;
      cfg_r.space1_time <= RST_SPACE1_TIME;
      cfg_r.wait_ticks  <= RST_WAIT_TICKS;
    end else if (wr_en) begin
      unique case (wr_idx)
        REG_NUM_BITS:    cfg_r.num_bits    <= wr_data[CNT_W-1:0];
        REG_PRE_BITS:    cfg_r.pre_bits    <= wr_data[PREB_W-1:0];
        REG_MARK_TIME:   cfg_r.mark_time   <= wr_data;
        REG_SPACE0_TIME: cfg_r.space0_time <= wr_data;
        REG_SPACE1_TIME: cfg_r.space1_time <= wr_data;
        REG_WAIT_TICKS:  cfg_r.wait_ticks  <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/core/irpd_seq.sv
// ----------------------------------------------------------------------------
// irpd_seq
// Frame sequencer: phase state, shift word, counters and the result register.
// ----------------------------------------------------------------------------
module irpd_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  irpd_pkg::item_t item,
  input  irpd_pkg::cfg_t  cfg,
  output irpd_pkg::res_t  res
);
  import irpd_pkg::*;

  phase_t              phase_r, phase_nxt;
  logic [CODE_W-1:0]   shift_r, shift_nxt;
  logic [CODE_W-1:0]   held_r, held_nxt;
  logic [CNT_W-1:0]    bcnt_r, bcnt_nxt;
  logic [TIME_W-1:0]   wcnt_r, wcnt_nxt;
  logic                carrier_r, carrier_nxt;
  logic [TIME_W-1:0]   interval_r, interval_nxt;
  logic                taken;
  logic [CNT_W-1:0]    bcnt_inc;
  logic [TIME_W-1:0]   wcnt_inc;
  logic [TIME_W-1:0]   space_len;
  res_t                res_r;

  assign bcnt_inc  = bcnt_r + CNT_W'(1);
  assign wcnt_inc  = wcnt_r + TIME_W'(1);
  assign space_len = shift_r[0] ? cfg.space1_time : cfg.space0_time;

  always_comb begin
    phase_nxt    = phase_r;
    shift_nxt    = shift_r;
    held_nxt     = held_r;
    bcnt_nxt     = bcnt_r;
    wcnt_nxt     = wcnt_r;
    carrier_nxt  = carrier_r;
    interval_nxt = interval_r;
    taken        = 1'b0;
    if (item.req_type == REQ_START) begin
      // a start is only taken between frames
      if (phase_r == PH_IDLE) begin
        taken    = 1'b1;
        bcnt_nxt = '0;
        wcnt_nxt = '0;
        held_nxt = item.code_word;
        if (cfg.pre_bits == '0) begin
          shift_nxt = item.code_word;
          phase_nxt = PH_BIT_A;
        end else begin
          shift_nxt = {{(CODE_W-PRE_W){1'b0}}, item.pre_word};
          phase_nxt = PH_PRE_A;
        end
      end
    end else begin
      unique case (phase_r)
        PH_PRE_A: begin
          interval_nxt = cfg.mark_time;
          carrier_nxt  = 1'b1;
          phase_nxt    = PH_PRE_B;
        end
        PH_BIT_A: begin
          interval_nxt = cfg.mark_time;
          carrier_nxt  = 1'b1;
          phase_nxt    = PH_BIT_B;
        end
        PH_PRE_B: begin
          carrier_nxt  = 1'b0;
          interval_nxt = space_len;
          if (bcnt_inc == {{(CNT_W-PREB_W){1'b0}}, cfg.pre_bits}) begin
            phase_nxt = PH_BIT_A;
            bcnt_nxt  = '0;
            shift_nxt = held_r;
          end else begin
            phase_nxt = PH_PRE_A;
            bcnt_nxt  = bcnt_inc;
            shift_nxt = shift_r >> 1;
          end
        end
        PH_BIT_B: begin
          carrier_nxt  = 1'b0;
          interval_nxt = space_len;
          bcnt_nxt     = bcnt_inc;
          shift_nxt    = shift_r >> 1;
          phase_nxt    = (bcnt_inc == cfg.num_bits) ? PH_STOP : PH_BIT_A;
        end
        PH_STOP: begin
          interval_nxt = cfg.mark_time;
          carrier_nxt  = 1'b1;
          phase_nxt    = PH_WAIT;
        end
        PH_WAIT: begin
          carrier_nxt = 1'b0;
          if (wcnt_inc >= cfg.wait_ticks) begin
            bcnt_nxt  = '0;
            wcnt_nxt  = '0;
            phase_nxt = PH_IDLE;
          end else begin
            wcnt_nxt = wcnt_inc;
          end
        end
        default: begin
          phase_nxt   = PH_IDLE;
          carrier_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      shift_r    <= '0;
      held_r     <= '0;
      bcnt_r     <= '0;
      wcnt_r     <= '0;
      carrier_r  <= 1'b0;
      interval_r <= RST_INTERVAL;
    end else if (step) begin
      phase_r    <= phase_nxt;
      shift_r    <= shift_nxt;
      held_r     <= held_nxt;
      bcnt_r     <= bcnt_nxt;
      wcnt_r     <= wcnt_nxt;
      carrier_r  <= carrier_nxt;
      interval_r <= interval_nxt;
    end
  end

  // result payload, qualified by the valid flag in the top level
  always_ff @(posedge clk) begin
    if (step) begin
      res_r.carrier_on      <= carrier_nxt;
      res_r.interval_length <= interval_nxt;
      res_r.busy_res        <= (phase_nxt != PH_IDLE);
      res_r.start_taken     <= taken;
    end
  end

  assign res = res_r;

endmodule

FILE: rtl/core/ir_pulse_distance_encoder.sv
// ----------------------------------------------------------------------------
// ir_pulse_distance_encoder
// Infrared pulse-distance transmitter sequencer with stream handshakes.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake        | payload
//   --------+-----------+------------------+---------------------------------
//   in_     | sink      | tvalid / tready  | tdata code/pre word, tuser kind
//   out_    | source    | tvalid / tready  | tdata carrier/interval/busy,
//           |           |                  | tuser start_taken
//   cfg_    | sink      | valid / ready    | index, data (always ready)
//
// one transaction per cycle while the result side keeps up; each item passes
// through the input register and then the result register.
// the result register is the only stall point: when it is full and not taken,
// the input register holds and in_tready drops.
// synchronous active-low reset returns to idle with reset timing values.
// ----------------------------------------------------------------------------
module ir_pulse_distance_encoder (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [39:0]                  in_tdata,  // code_word[31:0], pre_word[39:32]
  input  logic                         in_tuser,  // req_type
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [15:0]                  out_tdata, // carrier_on[0], interval_length[8:1],
                                                  // busy_res[9], zero[15:10]
  output logic                         out_tuser, // start_taken
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [irpd_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [irpd_pkg::CDATA_W-1:0] cfg_data
);
  import irpd_pkg::*;

  logic  in_vld_r;
  item_t item_r;
  logic  out_vld_r;
  logic  step;
  cfg_t  cfg;
  res_t  res;

  assign step      = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || step;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (step) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.req_type  <= in_tuser;
      item_r.code_word <= in_tdata[31:0];
      item_r.pre_word  <= in_tdata[39:32];
    end
  end

  irpd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid && cfg_ready),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  irpd_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'b0, res.busy_res, res.interval_length, res.carrier_on};
  assign out_tuser  = res.start_taken;

`ifndef SYNTHESIS
  // an accepted start always leaves a frame running
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res.start_taken |-> res.busy_res)
    else $error("start taken but sequencer idle");

  // carrier is only reported on inside a frame
  a_carrier_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res.carrier_on |-> res.busy_res)
    else $error("carrier on outside a frame");

  // input stalls only behind a full, blocked result register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> in_vld_r && out_vld_r && !out_tready)
    else $error("input stalled without back-pressure");

  // a processed item always produces a result next cycle
  a_step_result: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_vld_r)
    else $error("result lost after step");
`endif

endmodule

FILE: sim/tb_ir_pulse_distance_encoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ir_pulse_distance_encoder
// Self-checking bench for the infrared pulse-distance sequencer. A short
// table of directed items runs under the reset timing. Several timing
// settings follow, each with random frames and stray ticks and starts. A
// behavioral copy of the sequencer predicts the results of the random items
// and untyped table rows, and both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_ir_pulse_distance_encoder;
  import irpd_pkg::*;

  localparam logic [CIDX_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [CIDX_W-1:0] REG_UNUSED_HI = 3'd7;
  localparam int STALL_LIMIT = 1000;

  typedef struct {
    logic  kind;
    logic  [CODE_W-1:0] code;
    logic  [PRE_W-1:0]  pre;
    bit    typed;
    res_t  want;
    bit    drain;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [39:0]         in_tdata = '0;
  logic                in_tuser = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [15:0]         out_tdata;
  logic                out_tuser;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CIDX_W-1:0]   cfg_index = '0;
  logic [CDATA_W-1:0]  cfg_data = '0;

  // behavioral sequencer state
  cfg_t                seq_cfg;
  phase_t              seq_phase;
  logic [CODE_W-1:0]   seq_shift;
  logic [CODE_W-1:0]   seq_held;
  logic [CNT_W-1:0]    seq_bits;
  logic [TIME_W-1:0]   seq_wait;
  logic                seq_carrier;
  logic [TIME_W-1:0]   seq_interval;

  res_t                pending_pulses[$];
  stim_row_t           dir_rows[$];
  int                  mismatch_cnt = 0;
  int                  pulse_idx = 0;
  int                  quiet_cycles = 0;
  int                  rdy_left = 0;
  bit                  no_gaps = 1'b0;

  ir_pulse_distance_encoder uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void shift_space();
    seq_carrier = 1'b0;
    seq_interval = seq_shift[0] ? seq_cfg.space1_time : seq_cfg.space0_time;
    seq_shift = seq_shift >> 1;
    seq_bits = seq_bits + 1'b1;
  endfunction

  function automatic res_t step_sequencer(input logic kind, input logic [CODE_W-1:0] code,
                                          input logic [PRE_W-1:0] pre);
    res_t r;
    logic taken;
    taken = 1'b0;
    if (kind == REQ_START) begin
      if (seq_phase == PH_IDLE) begin
        seq_bits = '0;
        seq_wait = '0;
        seq_held = code;
        if (seq_cfg.pre_bits == '0) begin
          seq_shift = code;
          seq_phase = PH_BIT_A;
        end else begin
          seq_shift = {24'd0, pre};
          seq_phase = PH_PRE_A;
        end
        taken = 1'b1;
      end
    end else begin
      case (seq_phase) inside
        PH_PRE_A, PH_BIT_A: begin
          seq_interval = seq_cfg.mark_time;
          seq_carrier = 1'b1;
          seq_phase = (seq_phase == PH_PRE_A) ? PH_PRE_B : PH_BIT_B;
        end
        PH_PRE_B: begin
          shift_space();
          if (seq_bits == {2'b00, seq_cfg.pre_bits}) begin
            seq_phase = PH_BIT_A;
            seq_bits = '0;
            seq_shift = seq_held;
          end else begin
            seq_phase = PH_PRE_A;
          end
        end
        PH_BIT_B: begin
          shift_space();
          seq_phase = (seq_bits == seq_cfg.num_bits) ? PH_STOP : PH_BIT_A;
        end
        PH_STOP: begin
          seq_interval = seq_cfg.mark_time;
          seq_carrier = 1'b1;
          seq_phase = PH_WAIT;
        end
        PH_WAIT: begin
          seq_carrier = 1'b0;
          seq_wait = seq_wait + 1'b1;
          if (seq_wait >= seq_cfg.wait_ticks) begin
            seq_bits = '0;
            seq_wait = '0;
            seq_phase = PH_IDLE;
          end
        end
        default: begin
          seq_phase = PH_IDLE;
          seq_carrier = 1'b0;
        end
      endcase
    end
    r.carrier_on = seq_carrier;
    r.interval_length = seq_interval;
    r.busy_res = (seq_phase != PH_IDLE);
    r.start_taken = taken;
    return r;
  endfunction

  task automatic add_row(input logic kind, input logic [CODE_W-1:0] code,
                         input logic [PRE_W-1:0] pre, input bit typed, input res_t want,
                         input bit drain);
    stim_row_t row;
    row.kind = kind;
    row.code = code;
    row.pre = pre;
    row.typed = typed;
    row.want = want;
    row.drain = drain;
    dir_rows.push_back(row);
  endtask

  task automatic send_item(input logic kind, input logic [CODE_W-1:0] code,
                           input logic [PRE_W-1:0] pre, input bit typed, input res_t want);
    int gap;
    res_t pred;
    gap = gap_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {pre, code};
    do @(posedge clk); while (!in_tready);
    pred = step_sequencer(kind, code, pre);
    pending_pulses.push_back(typed ? want : pred);
  endtask

  task automatic drain_frame();
    while (seq_phase != PH_IDLE)
      send_item(REQ_TICK, $urandom, 8'($urandom), 1'b0, '0);
  endtask

  task automatic cfg_write(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_NUM_BITS:    seq_cfg.num_bits = data[CNT_W-1:0];
      REG_PRE_BITS:    seq_cfg.pre_bits = data[PREB_W-1:0];
      REG_MARK_TIME:   seq_cfg.mark_time = data;
      REG_SPACE0_TIME: seq_cfg.space0_time = data;
      REG_SPACE1_TIME: seq_cfg.space1_time = data;
      REG_WAIT_TICKS:  seq_cfg.wait_ticks = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // only called with the sequencer idle; unused bits of the data carry junk
  task automatic load_timing(input cfg_t s);
    logic [31:0] junk;
    junk = $urandom;
    in_tvalid <= 1'b0;
    while (pending_pulses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_write(REG_NUM_BITS, {junk[1:0], s.num_bits});
    cfg_write(REG_PRE_BITS, {junk[5:2], s.pre_bits});
    cfg_write(REG_MARK_TIME, s.mark_time);
    cfg_write(REG_SPACE0_TIME, s.space0_time);
    cfg_write(REG_SPACE1_TIME, s.space1_time);
    cfg_write(REG_WAIT_TICKS, s.wait_ticks);
    cfg_write(REG_UNUSED_LO, junk[15:8]);
    cfg_write(REG_UNUSED_HI, junk[23:16]);
  endtask

  task automatic run_frames(input int quota);
    int fed;
    logic kind;
    fed = 0;
    while (fed < quota) begin
      if (seq_phase == PH_IDLE)
        kind = ($urandom_range(0, 99) < 85) ? REQ_START : REQ_TICK;
      else
        kind = ($urandom_range(0, 99) < 6) ? REQ_START : REQ_TICK;
      if (kind == REQ_TICK || seq_phase == PH_IDLE) fed++;
      send_item(kind, $urandom, 8'($urandom), 1'b0, '0);
    end
    drain_frame();
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("result %0d %s: expected %0d, got %0d", pulse_idx, what, want, got);
  endtask

  always @(posedge clk) begin
    int r;
    if (rdy_left > 0) begin
      rdy_left--;
    end else if (no_gaps) begin
      out_tready <= 1'b1;
      rdy_left = 8;
    end else if (out_tready) begin
      r = gap_len();
      if (r > 0) begin
        out_tready <= 1'b0;
        rdy_left = r - 1;
      end else begin
        rdy_left = $urandom_range(0, 6);
      end
    end else begin
      out_tready <= 1'b1;
      rdy_left = $urandom_range(0, 6);
    end
  end

  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pulses.size() == 0) begin
        flag_mismatch("with nothing pending, tdata", '0, out_tdata);
      end else begin
        want = pending_pulses.pop_front();
        if (out_tdata[0] !== want.carrier_on)
          flag_mismatch("carrier_on", want.carrier_on, out_tdata[0]);
        if (out_tdata[8:1] !== want.interval_length)
          flag_mismatch("interval_length", want.interval_length, out_tdata[8:1]);
        if (out_tdata[9] !== want.busy_res)
          flag_mismatch("busy_res", want.busy_res, out_tdata[9]);
        if (out_tuser !== want.start_taken)
          flag_mismatch("start_taken", want.start_taken, out_tuser);
        if (out_tdata[15:10] !== '0)
          flag_mismatch("tdata padding", '0, out_tdata[15:10]);
      end
      pulse_idx++;
    end
  end

  // ends the run when no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    cfg_t plan[$];
    cfg_t s;

    seq_cfg.num_bits = RST_NUM_BITS;
    seq_cfg.pre_bits = RST_PRE_BITS;
    seq_cfg.mark_time = RST_MARK_TIME;
    seq_cfg.space0_time = RST_SPACE0_TIME;
    seq_cfg.space1_time = RST_SPACE1_TIME;
    seq_cfg.wait_ticks = RST_WAIT_TICKS;
    seq_phase = PH_IDLE;
    seq_shift = '0;
    seq_held = '0;
    seq_bits = '0;
    seq_wait = '0;
    seq_carrier = 1'b0;
    seq_interval = RST_INTERVAL;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset timing: 8 preamble bits, 32 code bits, marks 14, spaces 7 / 28
    add_row(REQ_TICK, 32'h0, 8'h00, 1'b1, {1'b0, 8'd20, 1'b0, 1'b0}, 1'b0);
    add_row(REQ_START, 32'hFFFF_FFFF, 8'h00, 1'b1, {1'b0, 8'd20, 1'b1, 1'b1}, 1'b0);
    add_row(REQ_START, 32'h0, 8'hFF, 1'b1, {1'b0, 8'd20, 1'b1, 1'b0}, 1'b0);
    add_row(REQ_TICK, 32'h0, 8'h00, 1'b1, {1'b1, 8'd14, 1'b1, 1'b0}, 1'b0);
    add_row(REQ_TICK, 32'h0, 8'h00, 1'b1, {1'b0, 8'd7, 1'b1, 1'b0}, 1'b0);
    add_row(REQ_TICK, 32'hFFFF_FFFF, 8'hFF, 1'b1, {1'b1, 8'd14, 1'b1, 1'b0}, 1'b0);
    add_row(REQ_TICK, 32'h0, 8'h00, 1'b0, '0, 1'b1);
    // idle after the wait keeps the stop mark length
    add_row(REQ_TICK, 32'h0, 8'h00, 1'b1, {1'b0, 8'd14, 1'b0, 1'b0}, 1'b0);
    add_row(REQ_START, 32'h0, 8'hFF, 1'b1, {1'b0, 8'd14, 1'b1, 1'b1}, 1'b0);
    add_row(REQ_TICK, 32'h0, 8'h00, 1'b1, {1'b1, 8'd14, 1'b1, 1'b0}, 1'b0);
    add_row(REQ_TICK, 32'h0, 8'h00, 1'b1, {1'b0, 8'd28, 1'b1, 1'b0}, 1'b1);

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].kind, dir_rows[i].code, dir_rows[i].pre,
                dir_rows[i].typed, dir_rows[i].want);
      if (dir_rows[i].drain) drain_frame();
    end

    // extremes, wrapped counts, words shorter than the bit counts
    plan.push_back('{6'd1, 4'd0, 8'd0, 8'd0, 8'd0, 8'd0});
    plan.push_back('{6'd32, 4'd8, 8'd255, 8'd255, 8'd255, 8'd255});
    plan.push_back('{6'd0, 4'd12, 8'd9, 8'd3, 8'd200, 8'd2});
    plan.push_back('{6'd45, 4'd15, 8'd1, 8'd254, 8'd2, 8'd1});
    repeat (4) begin
      s.num_bits = 6'($urandom_range(1, 32));
      s.pre_bits = 4'($urandom_range(0, 8));
      s.mark_time = 8'($urandom);
      s.space0_time = 8'($urandom);
      s.space1_time = 8'($urandom);
      s.wait_ticks = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
      plan.push_back(s);
    end

    foreach (plan[i]) begin
      load_timing(plan[i]);
      no_gaps = ($urandom_range(0, 3) == 0);
      run_frames(30);
    end

    in_tvalid <= 1'b0;
    while (pending_pulses.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/irpd_pkg.sv
rtl/core/irpd_cfg.sv
rtl/core/irpd_seq.sv
rtl/core/ir_pulse_distance_encoder.sv
sim/tb_ir_pulse_distance_encoder.sv
